// ===== sv/gcch_pkg.sv =====
`timescale 1ns / 1ps

package gcch_pkg;

  // Grid limits and derived widths
  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;
  localparam int DIM_W    = 9;                          // grid_rows / grid_cols / vertex fields
  localparam int RIDX_W   = $clog2(MAX_ROWS);           // cell row index
  localparam int CIDX_W   = $clog2(MAX_COLS);           // cell column index
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int TOTAL_W  = 2 * DIM_W;                  // rows * cols product
  localparam int CELL_W   = 32;
  localparam int HGT_W    = 34;
  localparam int NDV_W    = 24;
  localparam int FRAC_W   = 8;

  // Stream payload widths
  localparam int S_TDATA_W = 88;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS = 2'd0,
    CFG_GRID_COLS = 2'd1,
    CFG_NO_DATA   = 2'd2
  } cfg_idx_t;

  // Item kind carried on s_tuser
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Query sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_DATA,
    S_DONE
  } q_state_t;

  // Effective grid settings shared by the load and query units
  typedef struct packed {
    logic [DIM_W-1:0]  nr;
    logic [DIM_W-1:0]  nc;
    logic [CELL_W-1:0] marker;
  } grid_cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  // Clamp a raw grid dimension to 1..max
  function automatic logic [DIM_W-1:0] dim_used(input logic [DIM_W-1:0] raw,
                                                input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] d;
    d = raw;
    if (raw == '0) d = DIM_W'(1);
    else if (raw > max_dim) d = max_dim;
    return d;
  endfunction

endpackage

// ===== sv/gcch_ram.sv =====
`timescale 1ns / 1ps

module gcch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/gcch_load.sv =====
`timescale 1ns / 1ps

module gcch_load (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [gcch_pkg::CELL_W-1:0]   cell_altitude,
  input  logic [gcch_pkg::CELL_W-1:0]   lava_depth,
  input  gcch_pkg::grid_cfg_t           cfg,
  output gcch_pkg::wr_req_t             wr
);
  import gcch_pkg::*;

  logic [ADDR_W-1:0]  load_pointer;
  logic [ADDR_W-1:0]  load_pointer_next;
  logic [TOTAL_W-1:0] total;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W:0]    inc;
  logic [CELL_W:0]    sum;
  logic [CELL_W-1:0]  sat;

  // Cell count of the grid in use
  assign total = TOTAL_W'(cfg.nr * cfg.nc);

  // Restart at zero when the pointer lies beyond a shrunken grid
  assign waddr = (TOTAL_W'(load_pointer) >= total) ? '0 : load_pointer;
  assign inc   = {1'b0, waddr} + (ADDR_W+1)'(1);
  assign load_pointer_next = (TOTAL_W'(inc) >= total) ? '0 : inc[ADDR_W-1:0];

  // Saturate the altitude plus depth to signed 32 bits
  assign sum = {cell_altitude[CELL_W-1], cell_altitude} + {lava_depth[CELL_W-1], lava_depth};
  always_comb begin
    sat = sum[CELL_W-1:0];
    if (sum[CELL_W] != sum[CELL_W-1]) begin
      sat = sum[CELL_W] ? {1'b1, {(CELL_W-1){1'b0}}} : {1'b0, {(CELL_W-1){1'b1}}};
    end
  end

  assign wr.en   = load;
  assign wr.addr = waddr;
  assign wr.data = sat;

  // Advance the raster pointer on each load transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      load_pointer <= '0;
    end else if (load) begin
      load_pointer <= load_pointer_next;
    end
  end

endmodule

// ===== sv/gcch_query.sv =====
`timescale 1ns / 1ps

module gcch_query (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gcch_pkg::DIM_W-1:0]    vertex_row,
  input  logic [gcch_pkg::DIM_W-1:0]    vertex_col,
  input  gcch_pkg::grid_cfg_t           cfg,
  output gcch_pkg::rd_req_t             rd,
  input  logic [gcch_pkg::CELL_W-1:0]   rdata,
  output logic                          busy,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [gcch_pkg::HGT_W-1:0]    vertex_height,
  output logic                          out_of_range
);
  import gcch_pkg::*;

  q_state_t state, state_next;

  logic [RIDX_W-1:0] r0, r0_next, r1, r1_next;
  logic [CIDX_W-1:0] c0, c0_next, c1, c1_next;
  logic [RIDX_W-1:0] br, br_next, cr, cr_next;
  logic [CIDX_W-1:0] bc, bc_next, cc, cc_next;
  logic [HGT_W-1:0]  sum, sum_next;
  logic [1:0]        shamt, shamt_next;
  logic              oor, oor_next;
  logic              out_load;

  logic              vr_oor;
  logic [DIM_W-1:0]  vr_m1, vc_m1, nr_m1, nc_m1;
  logic [RIDX_W-1:0] r0_in, r1_in;
  logic [CIDX_W-1:0] c0_in, c1_in;
  logic              hit, col_ok, row_ok;
  logic [HGT_W-1:0]  height;

  assign busy = (state != S_IDLE);

  // Corner bounds, clamped to the grid in use
  assign vr_oor = (vertex_row > cfg.nr) || (vertex_col > cfg.nc);
  assign vr_m1  = vertex_row - DIM_W'(1);
  assign vc_m1  = vertex_col - DIM_W'(1);
  assign nr_m1  = cfg.nr - DIM_W'(1);
  assign nc_m1  = cfg.nc - DIM_W'(1);
  assign r0_in  = (vertex_row == '0) ? '0 : vr_m1[RIDX_W-1:0];
  assign r1_in  = (vertex_row >= cfg.nr) ? nr_m1[RIDX_W-1:0] : vertex_row[RIDX_W-1:0];
  assign c0_in  = (vertex_col == '0) ? '0 : vc_m1[CIDX_W-1:0];
  assign c1_in  = (vertex_col >= cfg.nc) ? nc_m1[CIDX_W-1:0] : vertex_col[CIDX_W-1:0];

  // Shared address unit: raster index of the cursor cell
  assign rd.addr = ADDR_W'(cr * cfg.nc + DIM_W'(cc));

  // Read the cell memory in the address state
  assign rd.en = (state == S_ADDR);

  // Compare unit and search bounds
  assign hit    = (rdata != cfg.marker);
  assign col_ok = (DIM_W'(cc) + DIM_W'(1)) < cfg.nc;
  assign row_ok = (DIM_W'(cr) + DIM_W'(1)) < cfg.nr;

  always_comb begin
    state_next = state;
    r0_next    = r0;
    r1_next    = r1;
    c0_next    = c0;
    c1_next    = c1;
    br_next    = br;
    bc_next    = bc;
    cr_next    = cr;
    cc_next    = cc;
    sum_next   = sum;
    shamt_next = shamt;
    oor_next   = oor;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          sum_next = '0;
          if (vr_oor) begin
            oor_next   = 1'b1;
            shamt_next = 2'd0;
            state_next = S_DONE;
          end else begin
            oor_next   = 1'b0;
            r0_next    = r0_in;
            r1_next    = r1_in;
            c0_next    = c0_in;
            c1_next    = c1_in;
            br_next    = r0_in;
            bc_next    = c0_in;
            cr_next    = r0_in;
            cc_next    = c0_in;
            // one cell: x4, two cells: x2, four cells: x1
            shamt_next = 2'(((r0_in == r1_in) ? 1 : 0) + ((c0_in == c1_in) ? 1 : 0));
            state_next = S_ADDR;
          end
        end
      end
      S_ADDR: begin
        state_next = S_DATA;
      end
      S_DATA: begin
        if (!hit && (col_ok || row_ok)) begin
          // Step the no-data search in raster order over the lower-right block
          if (col_ok) begin
            cc_next = cc + CIDX_W'(1);
          end else begin
            cr_next = cr + RIDX_W'(1);
            cc_next = bc;
          end
          state_next = S_ADDR;
        end else begin
          if (hit) begin
            sum_next = sum + {{(HGT_W-CELL_W){rdata[CELL_W-1]}}, rdata};
          end
          // Advance to the next cell of the corner
          if (bc != c1) begin
            bc_next    = bc + CIDX_W'(1);
            cr_next    = br;
            cc_next    = bc + CIDX_W'(1);
            state_next = S_ADDR;
          end else if (br != r1) begin
            br_next    = br + RIDX_W'(1);
            bc_next    = c0;
            cr_next    = br + RIDX_W'(1);
            cc_next    = c0;
            state_next = S_ADDR;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Scale the sum to Q.10
  always_comb begin
    case (shamt)
      2'd2:    height = sum << 2;
      2'd1:    height = sum << 1;
      default: height = sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    r0    <= r0_next;
    r1    <= r1_next;
    c0    <= c0_next;
    c1    <= c1_next;
    br    <= br_next;
    bc    <= bc_next;
    cr    <= cr_next;
    cc    <= cc_next;
    sum   <= sum_next;
    shamt <= shamt_next;
    oor   <= oor_next;
  end

  // Output register: hold until the receiver takes the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      vertex_height <= height;
      out_of_range  <= oor;
    end
  end

endmodule

// ===== sv/grid_cell_to_corner_height_core.sv =====
`timescale 1ns / 1ps

// Corner heights for a cell-centered terrain grid.
// Input stream s_*: s_tuser[0] selects the item kind (0 load a cell, 1 query
// a corner). Loads write altitude plus lava depth, saturated, to the next
// cell in raster order; they produce no result.
// Queries return one result on m_*: the averaged corner height in Q23.10 in
// m_tdata and the out-of-range flag in m_tuser[0].
// A query reads its one, two or four cells from the single cell memory,
// each in an address state, then a registered data state; an out-of-range
// corner reads no cell. A cell that holds the no-data marker starts a raster
// search of the cells below and to the right.
// s_tready is low while a query is busy; else loads are taken every cycle.
// The result sits in an output register; a stalled receiver holds it and the
// block waits for the register to free before finishing the next query.
// Configuration goes through cfg_*, always ready; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset sets a 1x1 grid, marker 0 and the load pointer to cell 0; the cell
// memory is not cleared and every cell must be loaded before it is queried.
module grid_cell_to_corner_height_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [31:0] cell_altitude, [63:32] lava_depth, [72:64] vertex_row,
  // [81:73] vertex_col, [87:82] zero
  input  logic [gcch_pkg::S_TDATA_W-1:0]     s_tdata,
  // [0] func
  input  logic [gcch_pkg::S_TUSER_W-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [33:0] vertex_height, [39:34] zero
  output logic [gcch_pkg::M_TDATA_W-1:0]     m_tdata,
  // [0] out_of_range
  output logic [gcch_pkg::M_TUSER_W-1:0]     m_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gcch_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gcch_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gcch_pkg::*;

  logic [DIM_W-1:0]  grid_rows;
  logic [DIM_W-1:0]  grid_cols;
  logic [NDV_W-1:0]  no_data_value;
  grid_cfg_t         cfg;
  wr_req_t           wr;
  rd_req_t           rd;
  logic [CELL_W-1:0] rdata;
  logic              busy;
  logic              accept;
  logic [HGT_W-1:0]  vertex_height;
  logic              out_of_range;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows     <= DIM_W'(1);
      grid_cols     <= DIM_W'(1);
      no_data_value <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GRID_ROWS: grid_rows     <= cfg_data[DIM_W-1:0];
        CFG_GRID_COLS: grid_cols     <= cfg_data[DIM_W-1:0];
        CFG_NO_DATA:   no_data_value <= cfg_data[NDV_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.nr     = dim_used(grid_rows, DIM_W'(MAX_ROWS));
  assign cfg.nc     = dim_used(grid_cols, DIM_W'(MAX_COLS));
  assign cfg.marker = {no_data_value, {FRAC_W{1'b0}}};

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;

  gcch_load u_load (
    .clk           (clk),
    .rst           (rst),
    .load          (accept && (s_tuser[0] == FUNC_LOAD)),
    .cell_altitude (s_tdata[31:0]),
    .lava_depth    (s_tdata[63:32]),
    .cfg           (cfg),
    .wr            (wr)
  );

  gcch_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (rdata)
  );

  gcch_query u_query (
    .clk           (clk),
    .rst           (rst),
    .start         (accept && (s_tuser[0] == FUNC_QUERY)),
    .vertex_row    (s_tdata[72:64]),
    .vertex_col    (s_tdata[81:73]),
    .cfg           (cfg),
    .rd            (rd),
    .rdata         (rdata),
    .busy          (busy),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .vertex_height (vertex_height),
    .out_of_range  (out_of_range)
  );

  assign m_tdata = {{(M_TDATA_W-HGT_W){1'b0}}, vertex_height};
  assign m_tuser = out_of_range;

endmodule

// ===== sv/gcch_chk.sv =====
`timescale 1ns / 1ps

module gcch_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic [gcch_pkg::S_TUSER_W-1:0]     s_tuser,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [gcch_pkg::M_TDATA_W-1:0]     m_tdata,
  input logic [gcch_pkg::M_TUSER_W-1:0]     m_tuser
);
  import gcch_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // An out-of-range corner reports height zero
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("out-of-range result with nonzero height");

  // A query transfer blocks the input in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == FUNC_QUERY) |=> !s_tready)
    else $error("input ready right after a query");

  // No result straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind grid_cell_to_corner_height_core gcch_chk u_chk (.*);

// ===== dv/corner_height_checker.sv =====
`timescale 1ns / 1ps

module corner_height_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  // [31:0] cell_altitude, [63:32] lava_depth, [72:64] vertex_row,
  // [81:73] vertex_col, [87:82] zero
  input  logic [gcch_pkg::S_TDATA_W-1:0]     s_tdata,
  // [0] func
  input  logic [gcch_pkg::S_TUSER_W-1:0]     s_tuser,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  // [33:0] vertex_height, [39:34] zero
  input  logic [gcch_pkg::M_TDATA_W-1:0]     m_tdata,
  // [0] out_of_range
  input  logic [gcch_pkg::M_TUSER_W-1:0]     m_tuser,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [gcch_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gcch_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                 fail_count,
  output int                                 pending
);

  import gcch_pkg::*;

  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [HGT_W-1:0] height;
    logic             oor;
  } corner_result_t;

  // Expected corner results, oldest first
  corner_result_t pending_heights[$];

  // Shadow of the cell memory and the register file
  logic signed [CELL_W-1:0] cells [DEPTH];
  logic [DIM_W-1:0]         rows_reg;
  logic [DIM_W-1:0]         cols_reg;
  logic signed [NDV_W-1:0]  marker_reg;
  int unsigned              fill_idx;
  int                       errors;

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] raw,
                                            input int unsigned lim);
    if (raw == '0) return 1;
    if (raw > lim) return lim;
    return 32'(raw);
  endfunction

  // Cell value, or the first valid cell of the block below and to the right
  function automatic longint cell_or_substitute(input int unsigned r, input int unsigned c,
                                                input int unsigned nr, input int unsigned nc,
                                                input longint mark);
    longint      v;
    int unsigned z;
    int unsigned k;
    v = longint'(cells[r * nc + c]);
    if (v != mark) return v;
    for (z = r; z < nr; z++) begin
      for (k = c; k < nc; k++) begin
        v = longint'(cells[z * nc + k]);
        if (v != mark) return v;
      end
    end
    return 0;
  endfunction

  // Saturate altitude plus depth and write it at the fill position
  function automatic void store_cell(input logic signed [CELL_W-1:0] alt,
                                     input logic signed [CELL_W-1:0] dep);
    longint      s;
    int unsigned total;
    total = clamp_dim(rows_reg, MAX_ROWS) * clamp_dim(cols_reg, MAX_COLS);
    s = longint'(alt) + longint'(dep);
    if (s > SUM_MAX) s = SUM_MAX;
    if (s < SUM_MIN) s = SUM_MIN;
    if (fill_idx >= total) fill_idx = 0;
    cells[fill_idx] = CELL_W'(s);
    fill_idx++;
    if (fill_idx >= total) fill_idx = 0;
  endfunction

  // Average of the one, two or four cells around a corner, Q.10
  function automatic corner_result_t predict_corner(input logic [DIM_W-1:0] vr_raw,
                                                    input logic [DIM_W-1:0] vc_raw);
    int unsigned    nr, nc, vr, vc, r0, r1, c0, c1, r, c, n;
    longint         sum, h, mark;
    corner_result_t res;
    nr = clamp_dim(rows_reg, MAX_ROWS);
    nc = clamp_dim(cols_reg, MAX_COLS);
    vr = 32'(vr_raw);
    vc = 32'(vc_raw);
    res = '0;
    if (vr > nr || vc > nc) begin
      res.oor = 1'b1;
      return res;
    end
    mark = longint'(marker_reg) * 256;
    r0 = (vr == 0) ? 0 : vr - 1;
    r1 = (vr >= nr) ? nr - 1 : vr;
    c0 = (vc == 0) ? 0 : vc - 1;
    c1 = (vc >= nc) ? nc - 1 : vc;
    sum = 0;
    for (r = r0; r <= r1; r++) begin
      for (c = c0; c <= c1; c++) begin
        sum += cell_or_substitute(r, c, nr, nc, mark);
      end
    end
    n = (r1 - r0 + 1) * (c1 - c0 + 1);
    case (n)
      1:       h = sum * 4;
      2:       h = sum * 2;
      default: h = sum;
    endcase
    res.height = HGT_W'(h);
    return res;
  endfunction

  // Track every transfer and compare results in order
  always @(posedge clk) begin
    corner_result_t got;
    corner_result_t want;
    if (rst) begin
      rows_reg   = DIM_W'(1);
      cols_reg   = DIM_W'(1);
      marker_reg = '0;
      fill_idx   = 0;
      errors     = 0;
      pending_heights.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GRID_ROWS: rows_reg = cfg_data[DIM_W-1:0];
          CFG_GRID_COLS: cols_reg = cfg_data[DIM_W-1:0];
          CFG_NO_DATA:   marker_reg = cfg_data[NDV_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == FUNC_LOAD) begin
          store_cell(s_tdata[31:0], s_tdata[63:32]);
        end else begin
          pending_heights = {pending_heights,
                             predict_corner(s_tdata[72:64], s_tdata[81:73])};
        end
      end
      if (m_tvalid && m_tready) begin
        got.height = m_tdata[HGT_W-1:0];
        got.oor    = m_tuser[0];
        if (pending_heights.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual height %0d oor %0b",
                   $time, $signed(got.height), got.oor);
        end else begin
          want = pending_heights.pop_front();
          if (got.height !== want.height) begin
            errors++;
            $display("%0t: vertex_height: expected %0d, actual %0d",
                     $time, $signed(want.height), $signed(got.height));
          end
          if (got.oor !== want.oor) begin
            errors++;
            $display("%0t: out_of_range: expected %0b, actual %0b",
                     $time, want.oor, got.oor);
          end
        end
      end
    end
    pending    <= pending_heights.size();
    fail_count <= errors;
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  import gcch_pkg::*;

  localparam int          SETTLE      = 16;
  localparam int          ITEM_TARGET = 1650;
  localparam int unsigned LIMIT       = 20000000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  logic [S_TUSER_W-1:0]  s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    fail_count;
  int                    pending;

  // Stimulus view of the grid in use
  int unsigned           rows_eff  = 1;
  int unsigned           cols_eff  = 1;
  logic [NDV_W-1:0]      marker_cur = '0;
  int unsigned           covered   = 0;
  int                    items_sent = 0;
  int                    burst_left = 0;
  int unsigned           cycles;

  grid_cell_to_corner_height_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  corner_height_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: switch between stall patterns every so often
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= ($urandom_range(0, 4) == 0);
      default: m_tready <= (stall_left % 4 != 0);
    endcase
  end

  // Transfer one item, opening a new burst with a random gap when due
  task automatic send_item(input logic func, input logic [31:0] alt, input logic [31:0] dep,
                           input logic [DIM_W-1:0] vr, input logic [DIM_W-1:0] vc);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 2);
        2:       gap = $urandom_range(1, 8);
        default: gap = $urandom_range(10, 30);
      endcase
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {6'b0, vc, vr, dep, alt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Pick a cell value: no-data hits, saturating sums, small and full-range values
  task automatic make_cell(input int mark_pct, output logic [31:0] alt, output logic [31:0] dep);
    logic [31:0]        target;
    logic signed [32:0] diff;
    int                 sel;
    target = {marker_cur, 8'h00};
    sel = $urandom_range(0, 99);
    if (sel < mark_pct) begin
      dep = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
      diff = $signed({target[31], target}) - $signed({dep[31], dep});
      if (diff[32] != diff[31]) begin
        alt = target;
        dep = '0;
      end else begin
        alt = diff[31:0];
      end
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        alt = {2'b01, 30'($urandom)};
        dep = {2'b01, 30'($urandom)};
        if ($urandom_range(0, 1)) begin
          alt = {2'b10, 30'($urandom)};
          dep = {2'b10, 30'($urandom)};
        end
      end else if (sel < 60) begin
        alt = $urandom_range(0, 2097152) - 1048576;
        dep = $urandom_range(0, 65536) - 32768;
      end else begin
        alt = $urandom;
        dep = $urandom;
      end
    end
  endtask

  task automatic send_load(input int mark_pct);
    logic [31:0] alt;
    logic [31:0] dep;
    make_cell(mark_pct, alt, dep);
    send_item(FUNC_LOAD, alt, dep, DIM_W'($urandom), DIM_W'($urandom));
  endtask

  // Corners mostly inside the grid, some just outside, some anywhere
  task automatic send_query();
    logic [DIM_W-1:0] vr;
    logic [DIM_W-1:0] vc;
    int               sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) vr = DIM_W'($urandom_range(0, rows_eff));
    else if (sel < 90) vr = DIM_W'(rows_eff + 1);
    else vr = DIM_W'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 80) vc = DIM_W'($urandom_range(0, cols_eff));
    else if (sel < 90) vc = DIM_W'(cols_eff + 1);
    else vc = DIM_W'($urandom);
    send_item(FUNC_QUERY, $urandom, $urandom, vr, vc);
  endtask

  // Hold the input until every pending result has been seen
  task automatic wait_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Drain, then write all registers back to back
  task automatic set_grid(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c,
                          input logic [NDV_W-1:0] m, input bit spare);
    wait_results();
    repeat (SETTLE) @(posedge clk);
    cfg_put(CFG_GRID_ROWS, {15'($urandom), r});
    cfg_put(CFG_GRID_COLS, {15'($urandom), c});
    cfg_put(CFG_NO_DATA, m);
    if (spare) cfg_put(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    rows_eff   = (r == 0) ? 1 : ((r > MAX_ROWS) ? MAX_ROWS : r);
    cols_eff   = (c == 0) ? 1 : ((c > MAX_COLS) ? MAX_COLS : c);
    marker_cur = m;
  endtask

  // New settings, fill the grid if needed, then mixed loads and queries
  task automatic run_phase(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c,
                           input logic [NDV_W-1:0] m, input int mark_pct,
                           input int n_mixed, input int q_pct, input bit spare);
    int unsigned total;
    int          pause_at;
    int          i;
    set_grid(r, c, m, spare);
    total = rows_eff * cols_eff;
    if (total > covered) begin
      repeat (total) send_load(mark_pct);
      covered = total;
    end
    pause_at = $urandom_range(0, n_mixed);
    for (i = 0; i < n_mixed; i++) begin
      if (i == pause_at && $urandom_range(0, 1)) wait_results();
      if ($urandom_range(0, 99) < q_pct) send_query();
      else send_load(mark_pct);
    end
  endtask

  // Cycle limit
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("grid_cell_to_corner_height_core: mismatch");
    $finish;
  end

  initial begin
    logic [DIM_W-1:0] rr;
    logic [DIM_W-1:0] cc;
    logic [NDV_W-1:0] mm;
    int               sel;
    int               pct;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: 1x1 grid, marker zero; a zero cell has no substitute
    send_item(FUNC_LOAD, 32'd5, -32'sd5, 9'd0, 9'd0);
    send_item(FUNC_QUERY, $urandom, $urandom, 9'd0, 9'd0);
    send_item(FUNC_QUERY, $urandom, $urandom, 9'd1, 9'd2);
    send_item(FUNC_LOAD, 32'h8000_0000, 32'hFFFF_FFFF, 9'd0, 9'd0);
    send_item(FUNC_QUERY, $urandom, $urandom, 9'd1, 9'd0);
    covered = 1;

    // 2x3 grid, marker -1: saturation both ways, a substitute, a missing tail
    set_grid(9'd2, 9'd3, -24'sd1, 1'b0);
    send_item(FUNC_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, DIM_W'($urandom), DIM_W'($urandom));
    send_item(FUNC_LOAD, -32'sd100, -32'sd156, DIM_W'($urandom), DIM_W'($urandom));
    send_item(FUNC_LOAD, 32'h8000_0000, 32'h8000_0000, DIM_W'($urandom), DIM_W'($urandom));
    send_item(FUNC_LOAD, 32'd12345, -32'sd345, DIM_W'($urandom), DIM_W'($urandom));
    send_item(FUNC_LOAD, 32'd0, 32'd0, DIM_W'($urandom), DIM_W'($urandom));
    send_item(FUNC_LOAD, -32'sd256, 32'd0, DIM_W'($urandom), DIM_W'($urandom));
    covered = 6;
    send_item(FUNC_QUERY, $urandom, $urandom, 9'd0, 9'd0);
    send_item(FUNC_QUERY, $urandom, $urandom, 9'd0, 9'd3);
    send_item(FUNC_QUERY, $urandom, $urandom, 9'd2, 9'd0);
    send_item(FUNC_QUERY, $urandom, $urandom, 9'd2, 9'd3);
    send_item(FUNC_QUERY, $urandom, $urandom, 9'd0, 9'd1);
    send_item(FUNC_QUERY, $urandom, $urandom, 9'd1, 9'd0);
    wait_results();
    send_item(FUNC_QUERY, $urandom, $urandom, 9'd1, 9'd1);
    send_item(FUNC_QUERY, $urandom, $urandom, 9'd1, 9'd2);
    send_item(FUNC_QUERY, $urandom, $urandom, 9'd1, 9'd3);
    send_item(FUNC_QUERY, $urandom, $urandom, 9'd3, 9'd0);
    send_item(FUNC_QUERY, $urandom, $urandom, 9'd0, 9'd4);
    send_item(FUNC_QUERY, $urandom, $urandom, 9'd511, 9'd511);

    // Extreme shapes and markers
    run_phase(9'd1, 9'd256, 24'h7F_FFFF, 30, 60, 70, 1'b1);
    run_phase(9'd256, 9'd1, 24'h80_0000, 30, 60, 70, 1'b0);
    run_phase(9'd511, 9'd2, NDV_W'($urandom), 30, 40, 70, 1'b0);
    run_phase(9'd2, 9'd300, 24'd0, 30, 40, 70, 1'b0);
    run_phase(9'd0, 9'd0, 24'h7F_FFFF, 50, 30, 60, 1'b0);
    run_phase(9'd5, 9'd6, 24'h80_0000, 100, 40, 70, 1'b0);
    run_phase(9'd4, 9'd3, 24'd0, 100, 40, 70, 1'b1);

    // Random settings, mostly small grids
    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      rr = (sel < 5) ? 9'd0 : ((sel < 65) ? 9'($urandom_range(1, 6)) : 9'($urandom_range(7, 16)));
      sel = $urandom_range(0, 99);
      cc = (sel < 5) ? 9'd0 : ((sel < 65) ? 9'($urandom_range(1, 6)) : 9'($urandom_range(7, 16)));
      sel = $urandom_range(0, 99);
      if (sel < 30) mm = '0;
      else if (sel < 40) mm = 24'h80_0000;
      else if (sel < 50) mm = 24'h7F_FFFF;
      else if (sel < 75) mm = NDV_W'($urandom_range(0, 100) - 50);
      else mm = NDV_W'($urandom);
      case ($urandom_range(0, 4))
        0:       pct = 0;
        1:       pct = 20;
        2:       pct = 50;
        3:       pct = 90;
        default: pct = 100;
      endcase
      run_phase(rr, cc, mm, pct, $urandom_range(40, 120), $urandom_range(30, 90),
                $urandom_range(0, 9) == 0);
    end

    // Drain and report
    wait_results();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("grid_cell_to_corner_height_core: match");
    end else begin
      $display("grid_cell_to_corner_height_core: mismatch");
    end
    $finish;
  end

endmodule
